// ===== rtl/core/rhl_pkg.sv =====
// Shared widths, curve tables and sideband types for the humidity linearizer.
// Depends on nothing; every RTL file references it by scoped names.
package rhl_pkg;

	localparam int ADC_W = 12;
	localparam int REF_W = 17;
	localparam int HUM_W = 14;
	localparam int NPTS  = 7;
	localparam int P_W   = 18;
	localparam int FRAC_W = 16;
	localparam int MQ    = 30;
	localparam int M_W   = MQ + 1;
	localparam int X_W   = ADC_W + P_W;
	localparam int E_W   = $clog2(X_W);
	localparam int LOG_W = E_W + FRAC_W;
	localparam int LOG_LAT = FRAC_W + 2;
	localparam int QUO_W = HUM_W;
	localparam int NUM_W = HUM_W + LOG_W + 1;
	localparam int SEG_W = $clog2(NPTS - 1);
	localparam int IDX_W = 1;

	localparam logic [IDX_W-1:0] REG_ENABLED = 1'd0;
	localparam logic [IDX_W-1:0] REG_REF_OHMS = 1'd1;
	localparam logic [REF_W-1:0] REF_RESET = 17'd10000;
	localparam logic [ADC_W-1:0] ADC_FULL = {ADC_W{1'b1}};

	localparam logic [P_W-1:0] CURVE_OHMS [NPTS] = '{
		18'd1000, 18'd2000, 18'd5000, 18'd10000, 18'd50000, 18'd100000, 18'd200000
	};
	localparam logic [HUM_W-1:0] CURVE_CENTI [NPTS] = '{
		14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000, 14'd9500, 14'd10000
	};

	typedef logic [LOG_W-1:0] span_arr_t [NPTS-1];

	typedef struct packed {
		logic en;
		logic zero;
		logic low;
		logic high;
		logic degen;
		logic [SEG_W-1:0] seg;
	} side_t;

	// Elaboration-time log2 in Q16, same squaring recurrence as the hardware unit.
	function automatic logic [LOG_W-1:0] log2_const(input logic [63:0] x);
		logic [63:0] m;
		logic [5:0] e;
		logic [FRAC_W-1:0] f;
		e = '0;
		f = '0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) e = 6'(i);
		end
		m = x << (6'(MQ) - e);
		for (int k = 0; k < FRAC_W; k++) begin
			m = (m * m) >> MQ;
			f = {f[FRAC_W-2:0], (m >= (64'd1 << (MQ + 1)))};
			if (m >= (64'd1 << (MQ + 1))) m = m >> 1;
		end
		return LOG_W'({e, f});
	endfunction

	function automatic span_arr_t calc_spans();
		span_arr_t s;
		logic [LOG_W-1:0] a;
		logic [LOG_W-1:0] b;
		for (int i = 0; i < NPTS - 1; i++) begin
			a = log2_const(64'(CURVE_OHMS[i]));
			b = log2_const(64'(CURVE_OHMS[i+1]));
			s[i] = (b > a) ? (b - a) : '0;
		end
		return s;
	endfunction

	localparam span_arr_t SEG_SPAN = calc_spans();

endpackage

// ===== rtl/core/rhl_log2.sv =====
// Pipelined fixed-point log2 (Q16) unit: normalize, then one squaring per stage.
// Depends on rhl_pkg for widths and the mantissa scale.
module rhl_log2 (
	input  logic clk,
	input  logic adv,
	input  logic [rhl_pkg::X_W-1:0] x,
	output logic [rhl_pkg::LOG_W-1:0] y
);

	logic [rhl_pkg::E_W-1:0] e_c;
	logic [rhl_pkg::X_W-1:0] x_s1;
	logic [rhl_pkg::E_W-1:0] e_s1;
	logic [rhl_pkg::M_W-1:0] m_s2;
	logic [rhl_pkg::E_W-1:0] e_s2;
	logic [rhl_pkg::M_W-1:0] m_sq [rhl_pkg::FRAC_W];
	logic [rhl_pkg::FRAC_W-1:0] f_sq [rhl_pkg::FRAC_W];
	logic [rhl_pkg::E_W-1:0] e_sq [rhl_pkg::FRAC_W];

	always_comb begin
		e_c = '0;
		for (int i = 0; i < rhl_pkg::X_W; i++) begin
			if (x[i]) e_c = rhl_pkg::E_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= x;
			e_s1 <= e_c;
			m_s2 <= {{(rhl_pkg::M_W-rhl_pkg::X_W){1'b0}}, x_s1}
				<< (rhl_pkg::E_W'(rhl_pkg::MQ) - e_s1);
			e_s2 <= e_s1;
		end
	end

	genvar k;
	generate
		for (k = 0; k < rhl_pkg::FRAC_W; k++) begin : g_sq
			logic [rhl_pkg::M_W-1:0] m_in;
			logic [rhl_pkg::FRAC_W-1:0] f_in;
			logic [rhl_pkg::E_W-1:0] e_in;
			logic [2*rhl_pkg::M_W-1:0] p;
			logic [rhl_pkg::M_W:0] t;
			if (k == 0) begin : g_first
				assign m_in = m_s2;
				assign f_in = '0;
				assign e_in = e_s2;
			end else begin : g_next
				assign m_in = m_sq[k-1];
				assign f_in = f_sq[k-1];
				assign e_in = e_sq[k-1];
			end
			assign p = m_in * m_in;
			assign t = p[2*rhl_pkg::M_W-1:rhl_pkg::MQ];
			always_ff @(posedge clk) begin
				if (adv) begin
					// A square at or above 2.0 yields a one bit and is halved.
					m_sq[k] <= t[rhl_pkg::M_W] ? t[rhl_pkg::M_W:1] : t[rhl_pkg::M_W-1:0];
					f_sq[k] <= {f_in[rhl_pkg::FRAC_W-2:0], t[rhl_pkg::M_W]};
					e_sq[k] <= e_in;
				end
			end
		end
	endgenerate

	assign y = {e_sq[rhl_pkg::FRAC_W-1], f_sq[rhl_pkg::FRAC_W-1]};

endmodule

// ===== rtl/core/rhl_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rhl_pkg for numerator, divisor and quotient widths.
module rhl_div (
	input  logic clk,
	input  logic adv,
	input  logic [rhl_pkg::NUM_W-1:0] num,
	input  logic [rhl_pkg::LOG_W-1:0] den,
	output logic [rhl_pkg::QUO_W-1:0] quo
);

	logic [rhl_pkg::NUM_W-1:0] rem_s [rhl_pkg::QUO_W];
	logic [rhl_pkg::LOG_W-1:0] den_s [rhl_pkg::QUO_W];
	logic [rhl_pkg::QUO_W-1:0] quo_s [rhl_pkg::QUO_W];

	genvar j;
	generate
		for (j = 0; j < rhl_pkg::QUO_W; j++) begin : g_st
			localparam int B = rhl_pkg::QUO_W - 1 - j;
			logic [rhl_pkg::NUM_W-1:0] r_in;
			logic [rhl_pkg::LOG_W-1:0] d_in;
			logic [rhl_pkg::QUO_W-1:0] q_in;
			logic [rhl_pkg::NUM_W-1:0] dsh;
			if (j == 0) begin : g_first
				assign r_in = num;
				assign d_in = den;
				assign q_in = '0;
			end else begin : g_next
				assign r_in = rem_s[j-1];
				assign d_in = den_s[j-1];
				assign q_in = quo_s[j-1];
			end
			assign dsh = {{(rhl_pkg::NUM_W-rhl_pkg::LOG_W){1'b0}}, d_in} << B;
			always_ff @(posedge clk) begin
				if (adv) begin
					den_s[j] <= d_in;
					if (r_in >= dsh) begin
						rem_s[j] <= r_in - dsh;
						quo_s[j] <= q_in | (rhl_pkg::QUO_W'(1) << B);
					end else begin
						rem_s[j] <= r_in;
						quo_s[j] <= q_in;
					end
				end
			end
		end
	endgenerate

	assign quo = quo_s[rhl_pkg::QUO_W-1];

endmodule

// ===== rtl/core/resistive_humidity_linearizer_top.sv =====
// Top level of the humidity linearizer: config registers, front end, log and
// divide pipelines, result select and output skid stage. Uses rhl_pkg, rhl_log2, rhl_div.
//
// Usage:
// - s_tvalid/s_tready/s_tdata carry one ADC sample per transaction (bits 11:0).
// - m_tvalid/m_tready/m_tdata/m_tuser return one result per sample, in order:
//   humidity in hundredths of a percent in m_tdata[13:0], reading_valid in m_tuser.
// - cfg_we/cfg_index/cfg_wdata write the enable (index 0) and the reference
//   resistor in ohms (index 1); write them only while no sample is in flight.
// - A result shows on m_tvalid once its sample has passed, in order,
//   three front-end stages, 18 in each log2 unit (normalize, shift, 16 squarings),
//   one scaling stage, 14 divider stages, one select stage and the output register;
//   the first of these loads at the accepting edge.
// - Throughput is one sample per cycle while the skid register is empty; every stage advances together.
// - When the receiver stalls, one more result is parked in a skid register, so
//   the input keeps taking samples until that register fills; nothing is lost.
// - Reset clears all valid bits, disables the reading and sets the reference
//   to 10000 ohms.
module resistive_humidity_linearizer_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [15:0] s_tdata,     // [11:0] adc_sample
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata,     // [13:0] humidity_centi
	output logic m_tuser,            // [0] reading_valid
	input  logic cfg_we,
	input  logic [rhl_pkg::IDX_W-1:0] cfg_index,
	input  logic [rhl_pkg::REF_W-1:0] cfg_wdata
);

	localparam int LL = rhl_pkg::LOG_LAT;
	localparam int DL = rhl_pkg::QUO_W;

	logic en_q;
	logic [rhl_pkg::REF_W-1:0] ref_q;
	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [rhl_pkg::ADC_W-1:0] adc_s1;
	logic en_s1, en_s2;
	logic [rhl_pkg::REF_W-1:0] ref_s1;
	logic [rhl_pkg::X_W-1:0] num_s2;
	logic [rhl_pkg::X_W-1:0] adcp_s2 [rhl_pkg::NPTS];
	logic zero_s2;
	rhl_pkg::side_t side_c, side_s3, side_s4;
	logic [rhl_pkg::X_W-1:0] xa_s3, xb_s3;
	logic [rhl_pkg::LOG_W-1:0] la, lb;
	logic lv_s [LL];
	rhl_pkg::side_t lside_s [LL];
	logic dv_s [DL];
	rhl_pkg::side_t dside_s [DL];
	logic [rhl_pkg::LOG_W-1:0] diff_c, dcl_c, span_c;
	logic [rhl_pkg::NUM_W-1:0] numer_s4;
	logic [rhl_pkg::LOG_W-1:0] den_s4;
	logic [rhl_pkg::QUO_W-1:0] quo;
	logic [rhl_pkg::HUM_W-1:0] hum_c, hum_s5;
	logic rv_s5;
	logic out_v_q, sk_v_q, out_rv_q, sk_rv_q;
	logic [rhl_pkg::HUM_W-1:0] out_h_q, sk_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			ref_q <= rhl_pkg::REF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rhl_pkg::REG_ENABLED: en_q <= cfg_wdata[0];
				rhl_pkg::REG_REF_OHMS: ref_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign adv = !sk_v_q;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i < LL; i++) lv_s[i] <= 1'b0;
			for (int i = 0; i < DL; i++) dv_s[i] <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			lv_s[0] <= v_s3;
			for (int i = 1; i < LL; i++) lv_s[i] <= lv_s[i-1];
			v_s4 <= lv_s[LL-1];
			dv_s[0] <= v_s4;
			for (int i = 1; i < DL; i++) dv_s[i] <= dv_s[i-1];
			v_s5 <= dv_s[DL-1];
		end
	end

	// Segment search: cross-multiplied compares against every curve point.
	always_comb begin
		side_c = '0;
		side_c.en = en_s2;
		side_c.zero = zero_s2;
		side_c.low = (num_s2 <= adcp_s2[0]);
		side_c.high = (num_s2 >= adcp_s2[rhl_pkg::NPTS-1]);
		side_c.seg = rhl_pkg::SEG_W'(rhl_pkg::NPTS - 2);
		for (int i = rhl_pkg::NPTS - 2; i >= 0; i--) begin
			if (num_s2 <= adcp_s2[i+1]) side_c.seg = rhl_pkg::SEG_W'(i);
		end
		side_c.degen = (rhl_pkg::SEG_SPAN[side_c.seg] == '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			adc_s1 <= s_tdata[rhl_pkg::ADC_W-1:0];
			en_s1 <= en_q;
			ref_s1 <= ref_q;
			num_s2 <= rhl_pkg::X_W'(ref_s1 * (rhl_pkg::ADC_FULL - adc_s1));
			for (int i = 0; i < rhl_pkg::NPTS; i++) begin
				adcp_s2[i] <= rhl_pkg::X_W'(adc_s1 * rhl_pkg::CURVE_OHMS[i]);
			end
			zero_s2 <= (adc_s1 == '0);
			en_s2 <= en_s1;
			side_s3 <= side_c;
			xa_s3 <= num_s2;
			xb_s3 <= adcp_s2[side_c.seg];
			lside_s[0] <= side_s3;
			for (int i = 1; i < LL; i++) lside_s[i] <= lside_s[i-1];
			side_s4 <= lside_s[LL-1];
			numer_s4 <= rhl_pkg::NUM_W'(
				(rhl_pkg::CURVE_CENTI[lside_s[LL-1].seg+1] - rhl_pkg::CURVE_CENTI[lside_s[LL-1].seg])
				* dcl_c) + rhl_pkg::NUM_W'(span_c >> 1);
			den_s4 <= span_c;
			dside_s[0] <= side_s4;
			for (int i = 1; i < DL; i++) dside_s[i] <= dside_s[i-1];
			hum_s5 <= hum_c;
			rv_s5 <= dside_s[DL-1].en;
		end
	end

	rhl_log2 u_log_num (.clk(clk), .adv(adv), .x(xa_s3), .y(la));
	rhl_log2 u_log_pt (.clk(clk), .adv(adv), .x(xb_s3), .y(lb));

	// Log distance into the segment, clamped to the segment span.
	always_comb begin
		span_c = rhl_pkg::SEG_SPAN[lside_s[LL-1].seg];
		diff_c = (la > lb) ? (la - lb) : '0;
		dcl_c = (diff_c > span_c) ? span_c : diff_c;
	end

	rhl_div u_div (.clk(clk), .adv(adv), .num(numer_s4), .den(den_s4), .quo(quo));

	always_comb begin
		rhl_pkg::side_t sd;
		sd = dside_s[DL-1];
		if (!sd.en) hum_c = '0;
		else if (sd.zero || sd.high) hum_c = rhl_pkg::CURVE_CENTI[rhl_pkg::NPTS-1];
		else if (sd.low) hum_c = rhl_pkg::CURVE_CENTI[0];
		else if (sd.degen) hum_c = rhl_pkg::CURVE_CENTI[sd.seg];
		else hum_c = rhl_pkg::CURVE_CENTI[sd.seg] + quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (sk_v_q) begin
				out_v_q <= 1'b1;
				sk_v_q <= 1'b0;
			end else begin
				out_v_q <= v_s5;
			end
		end else if (v_s5 && adv) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_h_q <= sk_v_q ? sk_h_q : hum_s5;
			out_rv_q <= sk_v_q ? sk_rv_q : rv_s5;
		end else if (adv) begin
			sk_h_q <= hum_s5;
			sk_rv_q <= rv_s5;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {{(16-rhl_pkg::HUM_W){1'b0}}, out_h_q};
	assign m_tuser = out_rv_q;

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_rv_q) |-> (out_h_q >= rhl_pkg::CURVE_CENTI[0]
			&& out_h_q <= rhl_pkg::CURVE_CENTI[rhl_pkg::NPTS-1]))
		else $error("humidity outside curve range");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_rv_q) |-> (out_h_q == '0))
		else $error("invalid reading carries nonzero humidity");
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid register full while output empty");
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(sk_v_q && !m_tready) |=> sk_v_q)
		else $error("parked result dropped during stall");

endmodule

// ===== bench/resistive_humidity_linearizer_top_test.sv =====
// Self-checking bench for the resistive humidity linearizer top level.
// Depends on rhl_pkg and resistive_humidity_linearizer_top; predicts each result in-line.
`timescale 1ns / 1ps

module resistive_humidity_linearizer_top_test;

	localparam int LATENCY = 40;
	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		logic [rhl_pkg::HUM_W-1:0] humidity;
		logic                      valid;
	} reading_t;

	typedef struct {
		logic [rhl_pkg::ADC_W-1:0] adc;
		logic                      known;
		logic [rhl_pkg::HUM_W-1:0] humidity;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata;     // [11:0] adc_sample
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;     // [13:0] humidity_centi
	logic m_tuser;            // [0] reading_valid
	logic cfg_we;
	logic [rhl_pkg::IDX_W-1:0] cfg_index;
	logic [rhl_pkg::REF_W-1:0] cfg_wdata;

	reading_t  pending_readings[$];
	logic      sensor_on;
	logic [rhl_pkg::REF_W-1:0] ref_ohms;
	int        error_count;
	int        readings_checked;
	int        idle_cycles;
	int        rx_phase;

	resistive_humidity_linearizer_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] log2_q16(input logic [63:0] x);
		logic [63:0] m;
		logic [63:0] e;
		logic [63:0] frac;
		e = 0;
		frac = 0;
		if (x == 0) return 0;
		while (e < 63 && (x >> (e + 1)) != 0) e++;
		m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
		for (int k = 0; k < 16; k++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd2 << 30)) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return (e << 16) | frac;
	endfunction

	function automatic logic [rhl_pkg::HUM_W-1:0] humidity_for(
		input logic [rhl_pkg::ADC_W-1:0] adc);
		logic [63:0] a;
		logic [63:0] num;
		logic [63:0] la;
		logic [63:0] lb;
		logic [63:0] span;
		logic [63:0] d;
		logic [63:0] dl;
		logic [63:0] pt_lo;
		logic [63:0] pt_hi;
		logic [63:0] h_lo;
		logic [63:0] h_hi;
		a = 64'(adc);
		if (a == 0) return rhl_pkg::CURVE_CENTI[rhl_pkg::NPTS-1];
		num = 64'(ref_ohms) * (64'(rhl_pkg::ADC_FULL) - a);
		if (num <= 64'(rhl_pkg::CURVE_OHMS[0]) * a) return rhl_pkg::CURVE_CENTI[0];
		if (num >= 64'(rhl_pkg::CURVE_OHMS[rhl_pkg::NPTS-1]) * a)
			return rhl_pkg::CURVE_CENTI[rhl_pkg::NPTS-1];
		for (int i = 0; i < rhl_pkg::NPTS - 1; i++) begin
			pt_lo = 64'(rhl_pkg::CURVE_OHMS[i]);
			pt_hi = 64'(rhl_pkg::CURVE_OHMS[i+1]);
			if (num <= pt_hi * a) begin
				h_lo = 64'(rhl_pkg::CURVE_CENTI[i]);
				h_hi = 64'(rhl_pkg::CURVE_CENTI[i+1]);
				la = log2_q16(pt_lo);
				lb = log2_q16(pt_hi);
				if (lb <= la) return h_lo[rhl_pkg::HUM_W-1:0];
				span = lb - la;
				dl = log2_q16(a * pt_lo);
				d = (log2_q16(num) > dl) ? log2_q16(num) - dl : 0;
				if (d > span) d = span;
				return rhl_pkg::HUM_W'(h_lo + ((h_hi - h_lo) * d + span / 2) / span);
			end
		end
		return rhl_pkg::CURVE_CENTI[rhl_pkg::NPTS-1];
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %0s: got %0d expected %0d (reading %0d)", what, got, want,
			readings_checked);
		error_count++;
	endtask

	// Receiver: stalls follow a slowly rotating pattern, with open stretches.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch("unexpected transaction", m_tdata, -1);
			end else begin
				want = pending_readings.pop_front();
				if (m_tdata[rhl_pkg::HUM_W-1:0] !== want.humidity)
					report_mismatch("humidity_centi", m_tdata[rhl_pkg::HUM_W-1:0], want.humidity);
				if (m_tuser !== want.valid)
					report_mismatch("reading_valid", m_tuser, want.valid);
			end
			readings_checked++;
		end
	end

	always @(negedge clk) begin
		rx_phase <= rx_phase + 1;
		if ((rx_phase / 64) % 3 == 0) m_tready <= 1'b1;
		else if ((rx_phase / 64) % 3 == 1) m_tready <= (rx_phase % 5) != 2;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// A cycle with no transaction on either side counts toward the watchdog.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d readings outstanding", pending_readings.size());
			$display("resistive_humidity_linearizer_top_test: FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [rhl_pkg::IDX_W-1:0] idx,
		input logic [rhl_pkg::REF_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == rhl_pkg::REG_ENABLED) sensor_on = value[0];
		else ref_ohms = value;
	endtask

	task automatic drain();
		while (pending_readings.size() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	// Presents one sample, waits for acceptance, and queues its prediction.
	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_sample(input logic [15:0] word, input logic known,
		input logic [rhl_pkg::HUM_W-1:0] typed);
		reading_t r;
		r.valid = sensor_on;
		r.humidity = sensor_on ? humidity_for(word[rhl_pkg::ADC_W-1:0]) : '0;
		if (known && r.humidity !== typed)
			report_mismatch("predictor vs table", r.humidity, typed);
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		pending_readings.push_back(r);
		@(negedge clk);
	endtask

	task automatic random_burst(input int count);
		int sent;
		int burst;
		logic [15:0] word;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 20);
			for (int b = 0; b < burst && sent < count; b++) begin
				word = 16'($urandom);
				case ($urandom_range(0, 5))
					0: word[11:0] = 12'($urandom_range(0, 40));
					1: word[11:0] = 12'($urandom_range(4050, 4095));
					default: ;
				endcase
				send_sample(word, 1'b0, '0);
				sent++;
			end
			// A gap drops tvalid; without one the next burst follows directly.
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
		s_tvalid <= 1'b0;
	endtask

	stim_row_t directed_rows[$];
	logic [rhl_pkg::REF_W-1:0] ref_settings[5];

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rhl_pkg::REG_ENABLED;
		cfg_wdata = '0;
		rx_phase = 0;
		idle_cycles = 0;
		error_count = 0;
		readings_checked = 0;
		sensor_on = 1'b0;
		ref_ohms = rhl_pkg::REF_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// After reset the sensor is off, so every reading is flagged invalid.
		send_sample(16'h0800, 1'b1, '0);
		send_sample(16'hFFFF, 1'b1, '0);
		s_tvalid <= 1'b0;
		drain();
		write_reg(rhl_pkg::REG_ENABLED, 1);

		// Zero sample is infinite resistance, full scale is zero resistance,
		// and upper input bits are ignored.
		directed_rows = '{
			'{12'd0, 1'b1, 14'd10000}, '{12'd4095, 1'b1, 14'd5000},
			'{12'd1, 1'b1, 14'd10000}, '{12'd2048, 1'b0, 14'd0},
			'{12'd3723, 1'b0, 14'd0}, '{12'd3412, 1'b0, 14'd0},
			'{12'd2730, 1'b0, 14'd0}, '{12'd1365, 1'b0, 14'd0},
			'{12'd372, 1'b0, 14'd0}, '{12'd195, 1'b0, 14'd0},
			'{12'd100, 1'b0, 14'd0}, '{12'd3000, 1'b0, 14'd0},
			'{12'd4094, 1'b1, 14'd5000}, '{12'd50, 1'b0, 14'd0}
		};
		foreach (directed_rows[i])
			send_sample({4'($urandom), directed_rows[i].adc}, directed_rows[i].known,
				directed_rows[i].humidity);
		s_tvalid <= 1'b0;
		drain();

		// Zero reference reads as zero resistance except for a zero sample.
		write_reg(rhl_pkg::REG_REF_OHMS, 0);
		send_sample(16'd0, 1'b1, 14'd10000);
		send_sample(16'd1000, 1'b1, 14'd5000);
		send_sample(16'hFFFE, 1'b1, 14'd5000);
		s_tvalid <= 1'b0;
		drain();

		ref_settings = '{17'd1000, 17'd100000, 17'h1FFFF, 17'd10000, 17'd33000};
		foreach (ref_settings[i]) begin
			write_reg(rhl_pkg::REG_REF_OHMS, ref_settings[i]);
			random_burst(80);
			drain();
		end
		write_reg(rhl_pkg::REG_ENABLED, 0);
		random_burst(30);
		drain();
		write_reg(rhl_pkg::REG_ENABLED, 1);
		write_reg(rhl_pkg::REG_REF_OHMS, 17'($urandom_range(1000, 100000)));
		random_burst(30);
		drain();

		$display("checked %0d readings over seven reference settings, both enable states,",
			readings_checked);
		$display("zero, full-scale and clamped samples, with sender gaps and receiver stalls");
		if (error_count == 0 && pending_readings.size() == 0) begin
			$display("resistive_humidity_linearizer_top_test: PASS");
		end else begin
			$display("resistive_humidity_linearizer_top_test: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/rhl_pkg.sv
rtl/core/rhl_log2.sv
rtl/core/rhl_div.sv
rtl/core/resistive_humidity_linearizer_top.sv
bench/resistive_humidity_linearizer_top_test.sv
